>>> rtl/pmh_pkg.sv
// ============================================================================
// pmh_pkg
// Shared types, codes and constants of the peak meter with hold.
// ============================================================================
package pmh_pkg;

    // Default number of channel stores.
    localparam int unsigned MAX_CHANNELS_DEF = 8;

    // Sample and coefficient widths are fixed by the item format.
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned COEF_W    = 16;
    localparam int unsigned AGE_W     = 16;
    localparam int unsigned CHAN_W    = 3;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // The channel field addresses at most this many channels.
    localparam int unsigned CHAN_LIMIT = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PEAK       = 2'd0,
        KIND_CLEAR_CLIP = 2'd1,
        KIND_RESET      = 2'd2,
        KIND_UNUSED     = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT   = 3'd0,
        REG_RELEASE_COEF    = 3'd1,
        REG_HOLD_DECAY_COEF = 3'd2,
        REG_HOLD_TICKS      = 3'd3,
        REG_CLIP_LEVEL      = 3'd4
    } cfg_reg_t;

    localparam logic [COUNT_W-1:0]  CHANNEL_COUNT_RST   = 4'd1;
    localparam logic [COEF_W-1:0]   RELEASE_COEF_RST    = 16'd58409;
    localparam logic [COEF_W-1:0]   HOLD_DECAY_COEF_RST = 16'd55134;
    localparam logic [AGE_W-1:0]    HOLD_TICKS_RST      = 16'd24;
    localparam logic [SAMPLE_W-1:0] CLIP_LEVEL_RST      = 16'd32735;

    // Configuration as seen by the datapath. The channel count is already
    // clamped to the range of channels that have storage.
    typedef struct packed {
        logic [COUNT_W-1:0]  active_count;
        logic [COEF_W-1:0]   release_coef;
        logic [COEF_W-1:0]   hold_decay_coef;
        logic [AGE_W-1:0]    hold_ticks;
        logic [SAMPLE_W-1:0] clip_level;
    } pmh_cfg_t;

    // Values read from one channel's stores.
    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] hold;
        logic [AGE_W-1:0]    age;
    } pmh_chan_t;

    // Outcome of one item.
    typedef struct packed {
        logic                wr_en;
        logic                clear_all;
        logic                clip;
        pmh_chan_t           chan;
        logic [SAMPLE_W-1:0] out_level;
        logic [SAMPLE_W-1:0] out_hold;
    } pmh_upd_t;

endpackage

>>> rtl/pmh_item_if.sv
// ============================================================================
// pmh_item_if
// Input channel of the peak meter: one peak, clear-clip or reset item.
// ============================================================================
interface pmh_item_if
    import pmh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] peak;

    modport source (output valid, output kind, output channel, output peak, input ready);
    modport sink   (input valid, input kind, input channel, input peak, output ready);
endinterface

>>> rtl/pmh_result_if.sv
// ============================================================================
// pmh_result_if
// Output channel of the peak meter: one channel's level, hold and clip state.
// ============================================================================
interface pmh_result_if
    import pmh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   out_channel;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] hold;
    logic                clip_latched;

    modport source (output valid, output out_channel, output level, output hold,
                    output clip_latched, input ready);
    modport sink   (input valid, input out_channel, input level, input hold,
                    input clip_latched, output ready);
endinterface

>>> rtl/pmh_cfg_regs.sv
// ============================================================================
// pmh_cfg_regs
// Configuration registers with the channel count clamped to stored channels.
// ============================================================================
module pmh_cfg_regs
    import pmh_pkg::*;
#(
    parameter int unsigned DEPTH = CHAN_LIMIT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output pmh_cfg_t              cfg
);

    logic [COUNT_W-1:0]  channel_count_reg;
    logic [COEF_W-1:0]   release_coef_reg;
    logic [COEF_W-1:0]   hold_decay_coef_reg;
    logic [AGE_W-1:0]    hold_ticks_reg;
    logic [SAMPLE_W-1:0] clip_level_reg;

    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg   <= CHANNEL_COUNT_RST;
            release_coef_reg    <= RELEASE_COEF_RST;
            hold_decay_coef_reg <= HOLD_DECAY_COEF_RST;
            hold_ticks_reg      <= HOLD_TICKS_RST;
            clip_level_reg      <= CLIP_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CHANNEL_COUNT:   channel_count_reg   <= cfg_data[COUNT_W-1:0];
                REG_RELEASE_COEF:    release_coef_reg    <= cfg_data[COEF_W-1:0];
                REG_HOLD_DECAY_COEF: hold_decay_coef_reg <= cfg_data[COEF_W-1:0];
                REG_HOLD_TICKS:      hold_ticks_reg      <= cfg_data[AGE_W-1:0];
                REG_CLIP_LEVEL:      clip_level_reg      <= cfg_data[SAMPLE_W-1:0];
                default:             ;
            endcase
        end
    end

    // A count of zero acts as one; a count past the stores acts as the store depth.
    always_comb
    begin
        if (channel_count_reg == '0)
            cfg.active_count = COUNT_W'(1);
        else if (channel_count_reg > DEPTH_CNT)
            cfg.active_count = DEPTH_CNT;
        else
            cfg.active_count = channel_count_reg;
        cfg.release_coef    = release_coef_reg;
        cfg.hold_decay_coef = hold_decay_coef_reg;
        cfg.hold_ticks      = hold_ticks_reg;
        cfg.clip_level      = clip_level_reg;
    end

endmodule

>>> rtl/pmh_update.sv
// ============================================================================
// pmh_update
// Per-item update of one channel's level, hold, hold age and the clip flag, or a clear of all channels.
// ============================================================================
module pmh_update
    import pmh_pkg::*;
(
    input  pmh_cfg_t            cfg,
    input  logic [KIND_W-1:0]   kind,
    input  logic                stored,
    input  logic                active,
    input  logic [SAMPLE_W-1:0] peak,
    input  pmh_chan_t           rd,
    input  logic                clip_in,
    output pmh_upd_t            upd
);

    logic [SAMPLE_W+COEF_W-1:0] level_prod;
    logic [SAMPLE_W+COEF_W-1:0] hold_prod;
    logic [SAMPLE_W-1:0]        level_decayed;
    logic [SAMPLE_W-1:0]        hold_decayed;
    logic [SAMPLE_W-1:0]        level_new;
    logic [AGE_W-1:0]           age_inc;
    pmh_chan_t                  peak_chan;

    // The two multiplies are independent, so they sit side by side.
    assign level_prod    = {{COEF_W{1'b0}}, rd.level} * {{SAMPLE_W{1'b0}}, cfg.release_coef};
    assign hold_prod     = {{COEF_W{1'b0}}, rd.hold} * {{SAMPLE_W{1'b0}}, cfg.hold_decay_coef};
    assign level_decayed = level_prod[SAMPLE_W+COEF_W-1:COEF_W];
    assign hold_decayed  = hold_prod[SAMPLE_W+COEF_W-1:COEF_W];
    assign level_new     = (peak > level_decayed) ? peak : level_decayed;
    assign age_inc       = (rd.age == '1) ? rd.age : rd.age + AGE_W'(1);

    always_comb
    begin
        peak_chan.level = level_new;
        if (peak >= rd.hold)
        begin
            peak_chan.hold = peak;
            peak_chan.age  = '0;
        end
        else
        begin
            peak_chan.age = age_inc;
            if (age_inc > cfg.hold_ticks)
                peak_chan.hold = (level_new > hold_decayed) ? level_new : hold_decayed;
            else
                peak_chan.hold = rd.hold;
        end
    end

    always_comb
    begin
        upd.wr_en     = 1'b0;
        upd.clear_all = 1'b0;
        upd.clip      = clip_in;
        upd.chan      = peak_chan;
        upd.out_level = stored ? rd.level : '0;
        upd.out_hold  = stored ? rd.hold : '0;
        case (kind_t'(kind))
            KIND_PEAK:
            begin
                if (active)
                begin
                    upd.wr_en     = 1'b1;
                    upd.clip      = clip_in | (peak >= cfg.clip_level);
                    upd.out_level = peak_chan.level;
                    upd.out_hold  = peak_chan.hold;
                end
            end
            KIND_CLEAR_CLIP:
                upd.clip = 1'b0;
            KIND_RESET:
            begin
                upd.clear_all = 1'b1;
                upd.clip      = 1'b0;
                upd.out_level = '0;
                upd.out_hold  = '0;
            end
            default:
                ;
        endcase
    end

endmodule

>>> rtl/peak_meter_with_hold.sv
// ============================================================================
// peak_meter_with_hold
// Multichannel audio peak meter with peak hold and a sticky clip flag.
//
// Every accepted item yields exactly one result, in order. An item is first
// captured in an input register; from there it reads its channel's level,
// hold and hold age, the update logic computes the new values, and as the
// item moves on the stores and the result register are written at the same
// edge. Because the stores are updated as the item leaves the input
// register, the following item always sees the values left by the one before
// it, so one item can be accepted in every clock cycle while results are
// taken. The result is offered from the result register. The longest path is
// the store read, one 16 by 16 multiply and two compare-and-select steps in
// series. The result register lets a new item be accepted while an earlier
// result waits to be taken; when the result side stalls, one further item is
// held in the input register and then the input stalls. Peak items carry
// unsigned amplitudes with full scale at 32768, and both decay coefficients
// are Q0.16 with truncating multiplies. A reset-meter item clears all channel
// stores and the clip flag at the same edge.
// Configuration registers must only be written while no item is in flight.
// ============================================================================
module peak_meter_with_hold
    import pmh_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pmh_item_if.sink              item,
    pmh_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Only channels the channel field can address are given storage.
    localparam int unsigned DEPTH = (MAX_CHANNELS < CHAN_LIMIT) ? MAX_CHANNELS : CHAN_LIMIT;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

    pmh_cfg_t cfg;

    // Input register.
    logic                s1_valid_reg;
    logic [KIND_W-1:0]   s1_kind_reg;
    logic [CHAN_W-1:0]   s1_chan_reg;
    logic [SAMPLE_W-1:0] s1_peak_reg;

    // Result register.
    logic                res_valid_reg;
    logic [CHAN_W-1:0]   res_chan_reg;
    logic [SAMPLE_W-1:0] res_level_reg;
    logic [SAMPLE_W-1:0] res_hold_reg;
    logic                res_clip_reg;

    // Channel stores and the clip flag.
    logic [SAMPLE_W-1:0] level_reg [DEPTH];
    logic [SAMPLE_W-1:0] hold_reg  [DEPTH];
    logic [AGE_W-1:0]    age_reg   [DEPTH];
    logic                clip_reg;

    logic                advance;
    logic                stored;
    logic                active;
    logic [IDX_W-1:0]    idx;
    pmh_chan_t           rd;
    pmh_upd_t            upd;

    pmh_cfg_regs #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The item in the input register moves on whenever the result register is
    // empty or its content is being taken in this cycle.
    assign advance    = s1_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;

    // A channel past the stores reads as zero and is never written.
    assign stored = {1'b0, s1_chan_reg} < DEPTH_CNT;
    assign active = {1'b0, s1_chan_reg} < cfg.active_count;
    assign idx    = stored ? s1_chan_reg[IDX_W-1:0] : '0;

    always_comb
    begin
        rd.level = level_reg[idx];
        rd.hold  = hold_reg[idx];
        rd.age   = age_reg[idx];
    end

    pmh_update u_update (
        .cfg     (cfg),
        .kind    (s1_kind_reg),
        .stored  (stored),
        .active  (active),
        .peak    (s1_peak_reg),
        .rd      (rd),
        .clip_in (clip_reg),
        .upd     (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_kind_reg <= item.kind;
            s1_chan_reg <= item.channel;
            s1_peak_reg <= item.peak;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_chan_reg  <= s1_chan_reg;
            res_level_reg <= upd.out_level;
            res_hold_reg  <= upd.out_hold;
            res_clip_reg  <= upd.clip;
        end
    end

    // The stores are written when the item leaves the input register, so the
    // next item already reads the updated values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                level_reg[i] <= '0;
                hold_reg[i]  <= '0;
                age_reg[i]   <= '0;
            end
        end
        else if (advance)
        begin
            clip_reg <= upd.clip;
            if (upd.clear_all)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    level_reg[i] <= '0;
                    hold_reg[i]  <= '0;
                    age_reg[i]   <= '0;
                end
            end
            else if (upd.wr_en)
            begin
                level_reg[idx] <= upd.chan.level;
                hold_reg[idx]  <= upd.chan.hold;
                age_reg[idx]   <= upd.chan.age;
            end
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.out_channel  = res_chan_reg;
    assign result.level        = res_level_reg;
    assign result.hold         = res_hold_reg;
    assign result.clip_latched = res_clip_reg;

    // A reset-meter item reports an all-zero channel and a clear clip flag.
    a_reset_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_kind_reg == KIND_RESET)
        |=> (result.level == '0) && (result.hold == '0) && !result.clip_latched)
        else $error("reset-meter item did not report zeros");

    // A peak at or above the clip level on an active channel latches the flag.
    a_clip_latches: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_kind_reg == KIND_PEAK) && active && stored
        && (s1_peak_reg >= cfg.clip_level)
        |=> clip_reg && result.clip_latched)
        else $error("clip flag not latched by a clipping peak");

    // The input side never stalls while the result register is empty.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> item.ready)
        else $error("input stalled with an empty result register");

    // The hold never falls below the level of a channel that was just updated.
    a_hold_above_level: assert property (@(posedge clk) disable iff (!rst_n)
        advance && upd.wr_en |-> (upd.chan.hold >= upd.chan.level))
        else $error("hold fell below level");

endmodule

>>> verif/tb_peak_meter_with_hold.sv
// ============================================================================
// tb_peak_meter_with_hold
// Self-checking testbench for the multichannel peak meter with peak hold.
//
// Commands for the meter go into a backlog queue, and a clocked driver moves
// them onto the item channel. Each command is run through a software copy of
// the meter at the moment its transfer completes. The expected reading
// goes into a queue, and a clocked monitor compares each output transfer
// against it, one field at a time. The run covers a short directed
// sequence and a hold-age run. It then runs several randomized phases
// under different register settings, with random idling, a long receiver
// hold-off and a full drain of the sender.
// ============================================================================
module tb_peak_meter_with_hold
    import pmh_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned SOAK_UPDATES  = 60;
    localparam int unsigned RX_HOLD_OFF   = 120;
    localparam int unsigned PHASE_ITEMS   = 90;

    // One command for the meter, as it travels on the item channel.
    typedef struct packed {
        kind_t               kind;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] peak;
    } meter_cmd_t;

    // One reading reported by the meter.
    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] hold;
        logic                clip;
    } meter_reading_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pmh_item_if   item_ch ();
    pmh_result_if result_ch ();

    peak_meter_with_hold u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Software copy of the meter: its registers and its channel stores.
    // ------------------------------------------------------------------------
    logic [COUNT_W-1:0]  m_count;
    logic [COEF_W-1:0]   m_release;
    logic [COEF_W-1:0]   m_hold_decay;
    logic [AGE_W-1:0]    m_hold_ticks;
    logic [SAMPLE_W-1:0] m_clip_level;

    logic [SAMPLE_W-1:0] level_mem [CHAN_LIMIT];
    logic [SAMPLE_W-1:0] hold_mem  [CHAN_LIMIT];
    logic [AGE_W-1:0]    age_mem   [CHAN_LIMIT];
    logic                clip_mem;

    meter_cmd_t     cmd_backlog[$];
    meter_reading_t expected_readings[$];

    int unsigned queued_count;
    int unsigned accepted_count;
    int unsigned readings_checked;
    int unsigned mismatches;
    int unsigned settings_applied;
    int unsigned cycle_count;

    // When steady is set, neither side idles.
    logic        steady;
    int unsigned rx_stalls_asked;
    int unsigned rx_stalls_served;
    int unsigned rx_hold_left;

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Q0.16 multiply with the fractional bits dropped.
    function automatic logic [SAMPLE_W-1:0] q16_mul(logic [SAMPLE_W-1:0] x,
                                                    logic [COEF_W-1:0] coef);
        logic [31:0] prod;
        prod = {16'd0, x} * {16'd0, coef};
        return prod[31:16];
    endfunction

    // A count of zero still means one channel, and the stores cap it at eight.
    function automatic int active_chans();
        if (m_count == 0)
            return 1;
        if (m_count > CHAN_LIMIT)
            return CHAN_LIMIT;
        return int'(m_count);
    endfunction

    function automatic void clear_meter();
        for (int i = 0; i < CHAN_LIMIT; i++)
        begin
            level_mem[i] = '0;
            hold_mem[i]  = '0;
            age_mem[i]   = '0;
        end
        clip_mem = 1'b0;
    endfunction

    // Apply one command to the software meter and return the reading that
    // the block should report for it.
    function automatic meter_reading_t next_reading(meter_cmd_t cmd);
        meter_reading_t rd;
        logic [SAMPLE_W-1:0] decayed;
        logic [SAMPLE_W-1:0] held;
        int ch;
        ch = int'(cmd.channel);
        case (cmd.kind)
            KIND_PEAK:
            begin
                // A peak on a channel beyond the active count is dropped.
                if (ch < active_chans())
                begin
                    if (cmd.peak >= m_clip_level)
                        clip_mem = 1'b1;
                    decayed = q16_mul(level_mem[ch], m_release);
                    level_mem[ch] = (cmd.peak > decayed) ? cmd.peak : decayed;
                    if (cmd.peak >= hold_mem[ch])
                    begin
                        hold_mem[ch] = cmd.peak;
                        age_mem[ch]  = '0;
                    end
                    else
                    begin
                        // The age saturates instead of wrapping around.
                        if (age_mem[ch] != '1)
                            age_mem[ch] = age_mem[ch] + 1'b1;
                        if (age_mem[ch] > m_hold_ticks)
                        begin
                            held = q16_mul(hold_mem[ch], m_hold_decay);
                            hold_mem[ch] = (level_mem[ch] > held) ? level_mem[ch] : held;
                        end
                    end
                end
            end
            KIND_CLEAR_CLIP: clip_mem = 1'b0;
            KIND_RESET:      clear_meter();
            default:         ;
        endcase
        rd.channel = cmd.channel;
        rd.level   = level_mem[ch];
        rd.hold    = hold_mem[ch];
        rd.clip    = clip_mem;
        return rd;
    endfunction

    // ------------------------------------------------------------------------
    // Item driver. A command is predicted at the edge where its transfer
    // completes. A new command is only put up once the channel is free, and
    // a command that has been offered stays up until it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        meter_cmd_t nxt;
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.kind    <= KIND_PEAK;
            item_ch.channel <= '0;
            item_ch.peak    <= '0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                nxt.kind    = kind_t'(item_ch.kind);
                nxt.channel = item_ch.channel;
                nxt.peak    = item_ch.peak;
                expected_readings.push_back(next_reading(nxt));
                accepted_count++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= 29))
                begin
                    nxt = cmd_backlog.pop_front();
                    item_ch.valid   <= 1'b1;
                    item_ch.kind    <= nxt.kind;
                    item_ch.channel <= nxt.channel;
                    item_ch.peak    <= nxt.peak;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. It checks each output transfer against the oldest
    // expected reading and drives ready. A hold-off that the stimulus asks
    // for is counted down here from RX_HOLD_OFF, and the receiver stays
    // stalled while it runs and the driver keeps offering commands.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        meter_reading_t exp_rd;
        if (!rst_n)
        begin
            result_ch.ready  <= 1'b0;
            rx_hold_left     <= 0;
            rx_stalls_served <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected reading: ch %0d level %0d hold %0d clip %0b",
                             $realtime, result_ch.out_channel, result_ch.level,
                             result_ch.hold, result_ch.clip_latched);
                    mismatches++;
                end
                else
                begin
                    exp_rd = expected_readings.pop_front();
                    readings_checked++;
                    if (result_ch.out_channel !== exp_rd.channel ||
                        result_ch.level !== exp_rd.level ||
                        result_ch.hold !== exp_rd.hold ||
                        result_ch.clip_latched !== exp_rd.clip)
                    begin
                        $display("%0t: reading mismatch: expected ch %0d level %0d hold %0d clip %0b",
                                 $realtime, exp_rd.channel, exp_rd.level, exp_rd.hold,
                                 exp_rd.clip);
                        $display("%0t: reading mismatch: got ch %0d level %0d hold %0d clip %0b",
                                 $realtime, result_ch.out_channel, result_ch.level,
                                 result_ch.hold, result_ch.clip_latched);
                        mismatches++;
                    end
                end
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left    <= rx_hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (rx_stalls_served != rx_stalls_asked)
            begin
                rx_stalls_served <= rx_stalls_served + 1;
                rx_hold_left     <= RX_HOLD_OFF;
                result_ch.ready  <= 1'b0;
            end
            else
            begin
                result_ch.ready <= steady || ($urandom_range(99) >= 29);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. A correct run ends long before this count is reached.
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d readings outstanding.",
                 cycle_count, expected_readings.size());
        $display("tb_peak_meter_with_hold: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_cmd(kind_t kind, logic [CHAN_W-1:0] channel,
                             logic [SAMPLE_W-1:0] peak);
        meter_cmd_t cmd;
        cmd.kind    = kind;
        cmd.channel = channel;
        cmd.peak    = peak;
        cmd_backlog.push_back(cmd);
        queued_count++;
    endtask

    // Wait until every queued command has been taken and every reading has
    // come back, then idle before returning.
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_readings.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Register writes happen only while the meter is idle, so the software
    // copy can take the new value at once.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CHANNEL_COUNT:   m_count      = val[COUNT_W-1:0];
            REG_RELEASE_COEF:    m_release    = val;
            REG_HOLD_DECAY_COEF: m_hold_decay = val;
            REG_HOLD_TICKS:      m_hold_ticks = val;
            REG_CLIP_LEVEL:      m_clip_level = val;
            default:             ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [COUNT_W-1:0] count, logic [COEF_W-1:0] rel,
                                 logic [COEF_W-1:0] hdc, logic [AGE_W-1:0] ticks,
                                 logic [SAMPLE_W-1:0] clip);
        write_reg(REG_CHANNEL_COUNT, {12'd0, count});
        write_reg(REG_RELEASE_COEF, rel);
        write_reg(REG_HOLD_DECAY_COEF, hdc);
        write_reg(REG_HOLD_TICKS, ticks);
        write_reg(REG_CLIP_LEVEL, clip);
        settings_applied++;
    endtask

    // Peak values lean toward the edges: silence, the top code, the clip
    // threshold and its neighbors, and quiet signals.
    function automatic logic [SAMPLE_W-1:0] pick_peak();
        int roll;
        int near;
        roll = $urandom_range(99);
        if (roll < 12)
            return '0;
        if (roll < 22)
            return '1;
        if (roll < 42)
        begin
            near = int'(m_clip_level) + int'($urandom_range(4)) - 2;
            if (near < 0)
                near = 0;
            if (near > 65535)
                near = 65535;
            return SAMPLE_W'(near);
        end
        if (roll < 67)
            return SAMPLE_W'($urandom_range(4095));
        return SAMPLE_W'($urandom_range(65535));
    endfunction

    // Most peaks go to an active channel, some to channels that are off.
    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(99) < 85)
            return CHAN_W'($urandom_range(active_chans() - 1));
        return CHAN_W'($urandom_range(CHAN_LIMIT - 1));
    endfunction

    // Random traffic. Most of it is runs on one channel: a peak followed by
    // quieter ones, which walks the hold through its age and decay. The rest
    // is single peaks and the other commands.
    task automatic random_traffic(int n);
        int pushed;
        int run_len;
        int roll;
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] top;
        pushed = 0;
        while (pushed < n)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                ch  = pick_channel();
                top = pick_peak();
                queue_cmd(KIND_PEAK, ch, top);
                run_len = $urandom_range(12, 2);
                for (int i = 0; i < run_len; i++)
                    queue_cmd(KIND_PEAK, ch, SAMPLE_W'($urandom_range(top)));
                pushed += run_len + 1;
            end
            else if (roll < 85)
            begin
                queue_cmd(KIND_PEAK, pick_channel(), pick_peak());
                pushed++;
            end
            else if (roll < 92)
            begin
                queue_cmd(KIND_CLEAR_CLIP, CHAN_W'($urandom_range(CHAN_LIMIT - 1)),
                          pick_peak());
                pushed++;
            end
            else if (roll < 96)
            begin
                queue_cmd(KIND_RESET, CHAN_W'($urandom_range(CHAN_LIMIT - 1)), pick_peak());
                pushed++;
            end
            else
            begin
                // The spare kind code must leave everything untouched.
                queue_cmd(KIND_UNUSED, CHAN_W'($urandom_range(CHAN_LIMIT - 1)), pick_peak());
                pushed++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_CHANNEL_COUNT;
        cfg_data         = '0;
        item_ch.valid    = 1'b0;
        item_ch.kind     = KIND_PEAK;
        item_ch.channel  = '0;
        item_ch.peak     = '0;
        result_ch.ready  = 1'b0;
        steady           = 1'b0;
        queued_count     = 0;
        accepted_count   = 0;
        readings_checked = 0;
        mismatches       = 0;
        settings_applied = 0;
        rx_stalls_asked  = 0;

        m_count      = CHANNEL_COUNT_RST;
        m_release    = RELEASE_COEF_RST;
        m_hold_decay = HOLD_DECAY_COEF_RST;
        m_hold_ticks = HOLD_TICKS_RST;
        m_clip_level = CLIP_LEVEL_RST;
        clear_meter();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset values: one active channel, clip
        // threshold just under full scale.
        queue_cmd(KIND_PEAK, 3'd0, 16'd0);
        queue_cmd(KIND_PEAK, 3'd0, 16'd65535);
        queue_cmd(KIND_CLEAR_CLIP, 3'd0, 16'd0);
        queue_cmd(KIND_PEAK, 3'd0, CLIP_LEVEL_RST - 1'b1);
        queue_cmd(KIND_PEAK, 3'd0, CLIP_LEVEL_RST);
        queue_cmd(KIND_UNUSED, 3'd0, 16'd65535);
        // Channels past the active count report their stores unchanged.
        queue_cmd(KIND_PEAK, 3'd1, 16'd500);
        queue_cmd(KIND_PEAK, 3'd7, 16'd65535);
        queue_cmd(KIND_RESET, 3'd3, 16'd0);
        wait_drained();

        // All eight channels, no hold time, a hold that collapses to the
        // level right away, and a clip level only the top code reaches.
        apply_setting(4'd8, 16'd65535, 16'd0, 16'd0, 16'd65535);
        queue_cmd(KIND_PEAK, 3'd7, 16'd40000);
        queue_cmd(KIND_PEAK, 3'd7, 16'd100);
        queue_cmd(KIND_PEAK, 3'd7, 16'd100);
        queue_cmd(KIND_PEAK, 3'd0, 16'd65535);
        queue_cmd(KIND_PEAK, 3'd3, 16'd65534);
        queue_cmd(KIND_CLEAR_CLIP, 3'd3, 16'd0);
        queue_cmd(KIND_UNUSED, 3'd7, 16'd0);
        queue_cmd(KIND_RESET, 3'd0, 16'd0);
        queue_cmd(KIND_PEAK, 3'd5, 16'd1);
        wait_drained();

        // Hold-age run: one loud peak followed by quiet ones. The hold stays
        // put while its age is within the hold time and then decays step by
        // step toward the level.
        apply_setting(4'd1, 16'd0, 16'd65535, 16'd40, 16'd65535);
        steady = 1'b1;
        queue_cmd(KIND_PEAK, 3'd0, 16'd60000);
        for (int i = 0; i < SOAK_UPDATES; i++)
            queue_cmd(KIND_PEAK, 3'd0, 16'd1);
        wait_drained();
        steady = 1'b0;
        queue_cmd(KIND_RESET, 3'd0, 16'd0);
        wait_drained();

        // Every coefficient at zero and a clip level of zero, so every peak
        // latches the flag and the level follows the peak exactly.
        apply_setting(4'd8, 16'd0, 16'd0, 16'd0, 16'd0);
        random_traffic(PHASE_ITEMS);
        wait_drained();

        // A count above eight and every other register at its top value.
        apply_setting(4'd15, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
        random_traffic(PHASE_ITEMS);
        wait_drained();

        // A count of zero acts as one channel. The receiver holds off for a
        // long stretch here, so the meter fills and stalls its input while
        // the driver keeps offering commands.
        apply_setting(4'd0, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      16'd3, 16'($urandom_range(40000, 20000)));
        rx_stalls_asked++;
        random_traffic(PHASE_ITEMS);
        wait_drained();

        // Random registers with a short hold time and no idling on either
        // side, so the meter runs at one item per cycle.
        apply_setting(4'($urandom_range(8, 1)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 16'($urandom_range(12)),
                      16'($urandom_range(65535)));
        steady = 1'b1;
        random_traffic(PHASE_ITEMS);
        wait_drained();
        steady = 1'b0;

        // Back to the usual ballistics with all channels on. The sender goes
        // quiet halfway until every reading has come back.
        apply_setting(4'd8, RELEASE_COEF_RST, HOLD_DECAY_COEF_RST, HOLD_TICKS_RST,
                      CLIP_LEVEL_RST);
        random_traffic(40);
        wait_drained();
        random_traffic(PHASE_ITEMS - 40);
        wait_drained();

        repeat (8) @(posedge clk);
        $display("Checked %0d readings under %0d register settings,",
                 readings_checked, settings_applied);
        $display("including a %0d-update hold-age run and a long receiver stall.",
                 SOAK_UPDATES);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0)
            $display("tb_peak_meter_with_hold: done, clean");
        else
            $display("tb_peak_meter_with_hold: done, errors");
        $finish;
    end

endmodule

>>> peak_meter_with_hold.f
rtl/pmh_pkg.sv
rtl/pmh_item_if.sv
rtl/pmh_result_if.sv
rtl/pmh_cfg_regs.sv
rtl/pmh_update.sv
rtl/peak_meter_with_hold.sv
verif/tb_peak_meter_with_hold.sv
